@@ src/hbvu_pkg.sv @@
package hbvu_pkg;

    // Coordinate format and falloff table size.
    localparam int COORD_FRAC_BITS  = 16;
    localparam int TRIG_TABLE_DEPTH = 256;
    localparam int K_BITS           = $clog2(TRIG_TABLE_DEPTH);

    // Flatten snap band, 0.1 in the coordinate format.
    localparam logic [33:0] FLAT_BAND = 34'(((1 << COORD_FRAC_BITS) + 5) / 10);

    // Brush modes.
    localparam logic [1:0] OP_RAISE   = 2'd0;
    localparam logic [1:0] OP_LOWER   = 2'd1;
    localparam logic [1:0] OP_FLATTEN = 2'd2;

    // Register map, indexed by paddr[3:2].
    localparam int         ADDR_BITS     = 4;
    localparam logic [1:0] REG_RADIUS    = 2'd0;
    localparam logic [1:0] REG_SPEED     = 2'd1;
    localparam logic [1:0] REG_BOOST     = 2'd2;
    localparam logic [30:0] RADIUS_RESET = 31'd327680;
    localparam logic [30:0] SPEED_RESET  = 31'd65536;
    localparam logic [15:0] BOOST_RESET  = 16'd512;

    // Square root pipeline: two result bits per stage.
    localparam int SQRT_STAGES    = 16;
    localparam int SQRT_STEPS     = 2;
    localparam int SQRT_REM_BITS  = 35;

    // Falloff arithmetic constants.
    localparam longint Q30_ONE       = 64'sd1073741824;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint SHADE_GAIN    = 64'sd19661;
    localparam longint TAYLOR_DENS [6] = '{132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] pick_x;
        logic signed [31:0] pick_y;
        logic signed [31:0] pick_z;
        logic [15:0]        frame_time;
        logic [1:0]         opcode;
        logic               boost;
        logic               apply;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_height;
        logic               inside_brush;
        logic [14:0]        highlight_shade;
    } t_out_item;

    typedef struct packed {
        logic [30:0] base_radius;
        logic [30:0] base_speed;
        logic [15:0] boost_multiplier;
    } t_cfg;

    // Per-item data that rides along the square root and divider stages.
    typedef struct packed {
        logic signed [31:0] vy;
        logic signed [31:0] py;
        logic [15:0]        ft;
        logic [1:0]         op;
        logic               apply;
        logic               in_brush;
        logic               below;
        logic               above;
        logic [30:0]        r;
        logic [30:0]        speed;
    } t_side;

    typedef logic [16:0] t_q16_lut [TRIG_TABLE_DEPTH];
    typedef logic [14:0] t_shade_lut [TRIG_TABLE_DEPTH];

    // cos(k/DEPTH * pi/2) in Q1.16 through a Taylor series in Q2.30.
    function automatic longint falloff_entry(input longint k);
        longint theta;
        longint t2;
        longint acc;
        longint prod;
        longint c;
        theta = (k * HALF_PI_Q30) / TRIG_TABLE_DEPTH;
        t2    = (theta * theta) >>> 30;
        acc   = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            prod = (t2 * acc) >>> 30;
            acc  = Q30_ONE - prod / TAYLOR_DENS[i];
            if (acc < 0) begin
                acc = 0;
            end
        end
        c = (acc + 64'sd8192) >>> 14;
        if (c > 64'sd65536) begin
            c = 64'sd65536;
        end
        return c;
    endfunction

    function automatic longint isqrt_const(input longint v);
        longint rem;
        longint res;
        longint bitv;
        rem  = v;
        res  = 0;
        bitv = 64'sd1 << 40;
        for (int i = 0; i < 21; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic t_q16_lut build_sqrt_lut();
        t_q16_lut lut;
        for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
            lut[k] = 17'(isqrt_const(falloff_entry(longint'(k)) << 16));
        end
        return lut;
    endfunction

    function automatic t_shade_lut build_shade_lut();
        t_shade_lut lut;
        for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
            lut[k] = 15'((SHADE_GAIN * falloff_entry(longint'(k)) + 64'sd32768) >>> 16);
        end
        return lut;
    endfunction

    localparam t_q16_lut   SQRT_C_LUT = build_sqrt_lut();
    localparam t_shade_lut SHADE_LUT  = build_shade_lut();

endpackage

@@ src/hbvu_regs.sv @@
module hbvu_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbvu_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output hbvu_pkg::t_cfg                 o_cfg
);

    hbvu_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_radius      <= hbvu_pkg::RADIUS_RESET;
            r_cfg.base_speed       <= hbvu_pkg::SPEED_RESET;
            r_cfg.boost_multiplier <= hbvu_pkg::BOOST_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                hbvu_pkg::REG_RADIUS: r_cfg.base_radius      <= pwdata[30:0];
                hbvu_pkg::REG_SPEED:  r_cfg.base_speed       <= pwdata[30:0];
                hbvu_pkg::REG_BOOST:  r_cfg.boost_multiplier <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hbvu_pkg::REG_RADIUS: prdata = {1'b0, r_cfg.base_radius};
            hbvu_pkg::REG_SPEED:  prdata = {1'b0, r_cfg.base_speed};
            hbvu_pkg::REG_BOOST:  prdata = {16'd0, r_cfg.boost_multiplier};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

@@ src/hbvu_sqrt_stage.sv @@
module hbvu_sqrt_stage (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  hbvu_pkg::t_side                        i_side,
    input  logic [63:0]                            i_rad,
    input  logic [hbvu_pkg::SQRT_REM_BITS-1:0]     i_rem,
    input  logic [31:0]                            i_root,
    output logic                                   o_valid,
    output hbvu_pkg::t_side                        o_side,
    output logic [63:0]                            o_rad,
    output logic [hbvu_pkg::SQRT_REM_BITS-1:0]     o_rem,
    output logic [31:0]                            o_root
);

    logic                                r_valid;
    hbvu_pkg::t_side                     r_side;
    logic [63:0]                         r_rad;
    logic [hbvu_pkg::SQRT_REM_BITS-1:0]  r_rem;
    logic [31:0]                         r_root;
    logic [63:0]                         n_rad;
    logic [hbvu_pkg::SQRT_REM_BITS-1:0]  n_rem;
    logic [31:0]                         n_root;
    logic [hbvu_pkg::SQRT_REM_BITS-1:0]  shifted;
    logic [hbvu_pkg::SQRT_REM_BITS-1:0]  trial;

    // Each step brings down two radicand bits and settles one root bit.
    always_comb begin
        n_rad  = i_rad;
        n_rem  = i_rem;
        n_root = i_root;
        shifted = '0;
        trial   = '0;
        for (int s = 0; s < hbvu_pkg::SQRT_STEPS; s++) begin
            shifted = {n_rem[hbvu_pkg::SQRT_REM_BITS-3:0], n_rad[63:62]};
            trial   = hbvu_pkg::SQRT_REM_BITS'({n_root, 2'b01});
            if (shifted >= trial) begin
                n_rem  = shifted - trial;
                n_root = {n_root[30:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_root = {n_root[30:0], 1'b0};
            end
            n_rad = {n_rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

@@ src/hbvu_div_stage.sv @@
module hbvu_div_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  hbvu_pkg::t_side              i_side,
    input  logic [31:0]                  i_rem,
    input  logic [hbvu_pkg::K_BITS-1:0]  i_quo,
    output logic                         o_valid,
    output hbvu_pkg::t_side              o_side,
    output logic [31:0]                  o_rem,
    output logic [hbvu_pkg::K_BITS-1:0]  o_quo
);

    logic                         r_valid;
    hbvu_pkg::t_side              r_side;
    logic [31:0]                  r_rem;
    logic [hbvu_pkg::K_BITS-1:0]  r_quo;
    logic [32:0]                  twice;
    logic [32:0]                  divisor;
    logic                         fits;

    // One restoring division step: the quotient bit of d*DEPTH/r.
    assign twice   = {i_rem, 1'b0};
    assign divisor = {2'b00, i_side.r};
    assign fits    = twice >= divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= fits ? 32'(twice - divisor) : twice[31:0];
            r_quo  <= {i_quo[hbvu_pkg::K_BITS-2:0], fits};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

@@ src/heightmap_brush_vertex_update_core.sv @@
// Terrain brush vertex update. One grid vertex enters per transfer and one
// result leaves per transfer, in order; the block takes a new vertex every
// cycle unless the output stalls. The pipeline depth is set mostly by the
// square root of the squared distance, which settles two root bits per
// stage over 16 stages, and by the falloff angle divider, which settles one
// index bit per stage. The input ready drops only while a finished result
// waits at the output and the consumer holds off; the whole pipeline then
// freezes, so nothing is lost or repeated. The three brush registers sit on
// an APB-style port at byte addresses 0 (radius), 4 (speed) and 8 (boost
// factor) and should be written only while no vertex is in flight.
module heightmap_brush_vertex_update_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hbvu_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hbvu_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbvu_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    hbvu_pkg::t_cfg cfg;
    logic           en;

    hbvu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline moves as one: it advances unless the output register
    // holds a result that is not being taken.
    logic                r_out_valid;
    hbvu_pkg::t_out_item r_out_item;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage A: boost products, absolute horizontal offsets and the flatten
    // band tests against the pick height.
    logic                 r_a_valid;
    hbvu_pkg::t_in_item   r_a_item;
    logic [46:0]          r_a_prod_r;
    logic [46:0]          r_a_prod_s;
    logic [30:0]          r_a_dxa;
    logic [30:0]          r_a_dza;
    logic                 r_a_far;
    logic                 r_a_below;
    logic                 r_a_above;
    logic signed [32:0]   dx;
    logic signed [32:0]   dz;
    logic [32:0]          dx_abs;
    logic [32:0]          dz_abs;
    logic signed [33:0]   vy_ext;
    logic signed [33:0]   py_ext;

    always_comb begin
        dx     = {i_in_data.pick_x[31], i_in_data.pick_x}
               - {i_in_data.vertex_x[31], i_in_data.vertex_x};
        dz     = {i_in_data.pick_z[31], i_in_data.pick_z}
               - {i_in_data.vertex_z[31], i_in_data.vertex_z};
        dx_abs = dx[32] ? 33'(-dx) : dx;
        dz_abs = dz[32] ? 33'(-dz) : dz;
        vy_ext = {{2{i_in_data.vertex_y[31]}}, i_in_data.vertex_y};
        py_ext = {{2{i_in_data.pick_y[31]}}, i_in_data.pick_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item   <= i_in_data;
            r_a_prod_r <= {16'd0, cfg.base_radius} * {31'd0, cfg.boost_multiplier};
            r_a_prod_s <= {16'd0, cfg.base_speed} * {31'd0, cfg.boost_multiplier};
            r_a_dxa    <= dx_abs[30:0];
            r_a_dza    <= dz_abs[30:0];
            // An offset of 2^31 or more always lands outside the brush.
            r_a_far    <= (dx_abs[32:31] != 2'b00) || (dz_abs[32:31] != 2'b00);
            r_a_below  <= vy_ext < (py_ext - $signed(hbvu_pkg::FLAT_BAND));
            r_a_above  <= vy_ext > (py_ext + $signed(hbvu_pkg::FLAT_BAND));
        end
    end

    // Stage B: saturate the boosted radius and speed, square the offsets.
    logic               r_b_valid;
    hbvu_pkg::t_in_item r_b_item;
    logic [30:0]        r_b_r;
    logic [30:0]        r_b_speed;
    logic [61:0]        r_b_dx2;
    logic [61:0]        r_b_dz2;
    logic               r_b_far;
    logic               r_b_below;
    logic               r_b_above;
    logic [30:0]        boost_r;
    logic [30:0]        boost_s;

    always_comb begin
        boost_r = (r_a_prod_r[46:39] != 8'd0) ? 31'h7FFF_FFFF : r_a_prod_r[38:8];
        boost_s = (r_a_prod_s[46:39] != 8'd0) ? 31'h7FFF_FFFF : r_a_prod_s[38:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_item  <= r_a_item;
            r_b_r     <= r_a_item.boost ? boost_r : cfg.base_radius;
            r_b_speed <= r_a_item.boost ? boost_s : cfg.base_speed;
            r_b_dx2   <= {31'd0, r_a_dxa} * {31'd0, r_a_dxa};
            r_b_dz2   <= {31'd0, r_a_dza} * {31'd0, r_a_dza};
            r_b_far   <= r_a_far;
            r_b_below <= r_a_below;
            r_b_above <= r_a_above;
        end
    end

    // Stage C: squared distance and squared radius.
    logic               r_c_valid;
    hbvu_pkg::t_in_item r_c_item;
    logic [30:0]        r_c_r;
    logic [30:0]        r_c_speed;
    logic [62:0]        r_c_dsq;
    logic [61:0]        r_c_rsq;
    logic               r_c_far;
    logic               r_c_below;
    logic               r_c_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_item  <= r_b_item;
            r_c_r     <= r_b_r;
            r_c_speed <= r_b_speed;
            r_c_dsq   <= {1'b0, r_b_dx2} + {1'b0, r_b_dz2};
            r_c_rsq   <= {31'd0, r_b_r} * {31'd0, r_b_r};
            r_c_far   <= r_b_far;
            r_c_below <= r_b_below;
            r_c_above <= r_b_above;
        end
    end

    // Stage D: the exact inside test, then the side data is bundled for
    // the long root and divider chain.
    logic            r_d_valid;
    hbvu_pkg::t_side r_d_side;
    logic [63:0]     r_d_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side.vy       <= r_c_item.vertex_y;
            r_d_side.py       <= r_c_item.pick_y;
            r_d_side.ft       <= r_c_item.frame_time;
            r_d_side.op       <= r_c_item.opcode;
            r_d_side.apply    <= r_c_item.apply;
            r_d_side.in_brush <= (r_c_r != 31'd0) && !r_c_far
                              && (r_c_dsq < {1'b0, r_c_rsq});
            r_d_side.below    <= r_c_below;
            r_d_side.above    <= r_c_above;
            r_d_side.r        <= r_c_r;
            r_d_side.speed    <= r_c_speed;
            r_d_rad           <= {1'b0, r_c_dsq};
        end
    end

    // Integer square root of the squared distance.
    logic                               sq_valid [hbvu_pkg::SQRT_STAGES+1];
    hbvu_pkg::t_side                    sq_side  [hbvu_pkg::SQRT_STAGES+1];
    logic [63:0]                        sq_rad   [hbvu_pkg::SQRT_STAGES+1];
    logic [hbvu_pkg::SQRT_REM_BITS-1:0] sq_rem   [hbvu_pkg::SQRT_STAGES+1];
    logic [31:0]                        sq_root  [hbvu_pkg::SQRT_STAGES+1];

    assign sq_valid[0] = r_d_valid;
    assign sq_side[0]  = r_d_side;
    assign sq_rad[0]   = r_d_rad;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = 32'd0;

    for (genvar g = 0; g < hbvu_pkg::SQRT_STAGES; g++) begin : g_sqrt
        hbvu_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[g]),
            .i_side  (sq_side[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_valid (sq_valid[g+1]),
            .o_side  (sq_side[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    // Angle index k = floor(d*DEPTH/r). Inside the brush d < r, so the
    // quotient always fits the table.
    logic                        dv_valid [hbvu_pkg::K_BITS+1];
    hbvu_pkg::t_side             dv_side  [hbvu_pkg::K_BITS+1];
    logic [31:0]                 dv_rem   [hbvu_pkg::K_BITS+1];
    logic [hbvu_pkg::K_BITS-1:0] dv_quo   [hbvu_pkg::K_BITS+1];

    assign dv_valid[0] = sq_valid[hbvu_pkg::SQRT_STAGES];
    assign dv_side[0]  = sq_side[hbvu_pkg::SQRT_STAGES];
    assign dv_rem[0]   = sq_root[hbvu_pkg::SQRT_STAGES];
    assign dv_quo[0]   = '0;

    for (genvar g = 0; g < hbvu_pkg::K_BITS; g++) begin : g_div
        hbvu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_side  (dv_side[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .o_valid (dv_valid[g+1]),
            .o_side  (dv_side[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1])
        );
    end

    // Stage T: falloff tables give the root of the cosine and the shade.
    logic            r_t_valid;
    hbvu_pkg::t_side r_t_side;
    logic [16:0]     r_t_sc;
    logic [14:0]     r_t_shade;
    logic [hbvu_pkg::K_BITS-1:0] k_idx;

    assign k_idx = dv_quo[hbvu_pkg::K_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= dv_valid[hbvu_pkg::K_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_side  <= dv_side[hbvu_pkg::K_BITS];
            r_t_sc    <= hbvu_pkg::SQRT_C_LUT[k_idx];
            r_t_shade <= dv_side[hbvu_pkg::K_BITS].in_brush
                       ? hbvu_pkg::SHADE_LUT[k_idx] : 15'd0;
        end
    end

    // Stage M1: sqrt(c) times frame time.
    logic            r_m1_valid;
    hbvu_pkg::t_side r_m1_side;
    logic [14:0]     r_m1_shade;
    logic [32:0]     r_m1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_side  <= r_t_side;
            r_m1_shade <= r_t_shade;
            r_m1_prod  <= {16'd0, r_t_sc} * {17'd0, r_t_side.ft};
        end
    end

    // Stage M2: times speed; the step keeps the upper word.
    logic            r_m2_valid;
    hbvu_pkg::t_side r_m2_side;
    logic [14:0]     r_m2_shade;
    logic [30:0]     r_m2_step;
    logic [63:0]     step_prod;

    assign step_prod = {31'd0, r_m1_prod} * {33'd0, r_m1_side.speed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_side  <= r_m1_side;
            r_m2_shade <= r_m1_shade;
            r_m2_step  <= step_prod[62:32];
        end
    end

    // Output stage: apply the step by mode with signed saturation.
    logic signed [32:0] sum_up;
    logic signed [32:0] sum_dn;
    logic signed [31:0] h_up;
    logic signed [31:0] h_dn;
    logic signed [31:0] n_height;

    always_comb begin
        sum_up = {r_m2_side.vy[31], r_m2_side.vy} + {2'b00, r_m2_step};
        sum_dn = {r_m2_side.vy[31], r_m2_side.vy} - {2'b00, r_m2_step};
        h_up   = (sum_up[32] != sum_up[31]) ? 32'sh7FFF_FFFF : sum_up[31:0];
        h_dn   = (sum_dn[32] != sum_dn[31]) ? 32'sh8000_0000 : sum_dn[31:0];
        n_height = r_m2_side.vy;
        if (r_m2_side.in_brush && r_m2_side.apply) begin
            case (r_m2_side.op)
                hbvu_pkg::OP_RAISE: n_height = h_up;
                hbvu_pkg::OP_LOWER: n_height = h_dn;
                hbvu_pkg::OP_FLATTEN: begin
                    if (r_m2_side.below) begin
                        n_height = h_up;
                    end else if (r_m2_side.above) begin
                        n_height = h_dn;
                    end else begin
                        n_height = r_m2_side.py;
                    end
                end
                default: n_height = r_m2_side.vy;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.new_height      <= n_height;
            r_out_item.inside_brush    <= r_m2_side.in_brush;
            r_out_item.highlight_shade <= r_m2_shade;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // A vertex outside the brush is never shaded.
    a_outside_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.inside_brush) |-> (r_out_item.highlight_shade == 15'd0))
        else $error("shade set on a vertex outside the brush");

    // The shade never exceeds 0.3 in Q0.16.
    a_shade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.highlight_shade <= 15'd19661))
        else $error("shade above its range");

    // A held result freezes the inner stages as well.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_t_sc) && $stable(r_m2_step)
                                           && $stable(r_d_valid)))
        else $error("pipeline moved during an output stall");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid right after reset");

endmodule

@@ tb/sv/hbvu_checker.sv @@
module hbvu_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  hbvu_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hbvu_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_val,
    output int                  o_fail_count,
    output int                  o_pending
);
    import hbvu_pkg::*;

    logic [30:0] radius_reg;
    logic [30:0] speed_reg;
    logic [15:0] boost_reg;
    t_out_item   brush_results_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned scale_by_boost(input longint unsigned base_v,
                                                      input logic on);
        longint unsigned v;
        if (!on) return base_v;
        v = (base_v * boost_reg) >> 8;
        return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
    endfunction

    // Cosine falloff, Q2.30 Taylor series rounded to Q1.16.
    function automatic longint cos_falloff(input longint k);
        longint dens[6];
        longint theta;
        longint t2;
        longint acc;
        longint prod;
        longint c;
        dens = '{132, 90, 56, 30, 12, 2};
        theta = (k * 64'sd1686629713) / TRIG_TABLE_DEPTH;
        t2 = (theta * theta) >>> 30;
        acc = 64'sd1073741824;
        for (int i = 0; i < 6; i++) begin
            prod = (t2 * acc) >>> 30;
            acc = 64'sd1073741824 - prod / dens[i];
            if (acc < 0) acc = 0;
        end
        c = (acc + 64'sd8192) >>> 14;
        return (c > 65536) ? 65536 : c;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_out_item brush_vertex(input t_in_item it);
        t_out_item       res;
        longint unsigned r;
        longint unsigned spd;
        longint unsigned dsq;
        longint unsigned d;
        longint unsigned k;
        longint unsigned c;
        longint unsigned sc;
        longint unsigned stp;
        longint          dx;
        longint          dz;
        longint          vy;
        longint          py;
        longint          h;
        longint          band;
        r = scale_by_boost(radius_reg, it.boost);
        spd = scale_by_boost(speed_reg, it.boost);
        dx = longint'(it.pick_x) - longint'(it.vertex_x);
        dz = longint'(it.pick_z) - longint'(it.vertex_z);
        if (dx < 0) dx = -dx;
        if (dz < 0) dz = -dz;
        vy = it.vertex_y;
        py = it.pick_y;
        h = vy;
        res.inside_brush = 1'b0;
        res.highlight_shade = '0;
        if (r != 0 && dx <= 64'sd2147483647 && dz <= 64'sd2147483647) begin
            dsq = dx * dx + dz * dz;
            if (dsq < r * r) begin
                d = int_sqrt(dsq);
                k = d * TRIG_TABLE_DEPTH / r;
                if (k >= TRIG_TABLE_DEPTH) k = TRIG_TABLE_DEPTH - 1;
                band = ((64'sd1 << COORD_FRAC_BITS) + 5) / 10;
                res.inside_brush = 1'b1;
                c = cos_falloff(k);
                res.highlight_shade = 15'((64'd19661 * c + 64'd32768) >> 16);
                sc = int_sqrt(c << 16);
                stp = (sc * it.frame_time * spd) >> 32;
                if (it.apply) begin
                    case (it.opcode)
                        OP_RAISE: h = clamp_s32(vy + longint'(stp));
                        OP_LOWER: h = clamp_s32(vy - longint'(stp));
                        OP_FLATTEN: begin
                            if (vy < py - band) h = clamp_s32(vy + longint'(stp));
                            else if (vy > py + band) h = clamp_s32(vy - longint'(stp));
                            else h = py;
                        end
                        default: h = vy;
                    endcase
                end
            end
        end
        res.new_height = 32'(h);
        return res;
    endfunction

    assign o_pending = brush_results_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            radius_reg <= RADIUS_RESET;
            speed_reg <= SPEED_RESET;
            boost_reg <= BOOST_RESET;
            o_fail_count <= 0;
            brush_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RADIUS: radius_reg <= i_cfg_val[30:0];
                    REG_SPEED: speed_reg <= i_cfg_val[30:0];
                    REG_BOOST: boost_reg <= i_cfg_val[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) brush_results_q.push_back(brush_vertex(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (brush_results_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = brush_results_q.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected h=%h in=%b sh=%h got h=%h in=%b sh=%h",
                                 $time, want.new_height, want.inside_brush,
                                 want.highlight_shade, i_out_data.new_height,
                                 i_out_data.inside_brush, i_out_data.highlight_shade);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/heightmap_brush_vertex_update_core_tb.sv @@
// Top of the brush testbench. It drives vertex transfers in random bursts,
// stalls the result side on its own pattern, programs the brush registers
// between phases, and reports the verdict from the checker's failure count.
module heightmap_brush_vertex_update_core_tb;
    import hbvu_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out_item            out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    longint               cycle_count = 0;
    int                   stall_mode = 0;

    heightmap_brush_vertex_update_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The checker mirrors a register write at the same edge the block takes it.
    hbvu_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[3:2]), .i_cfg_val(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Global watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The result side switches among always ready, random stalls and long holds.
    always @(negedge clk) begin
        if (($urandom_range(0, 63)) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold the payload until the block takes the transfer, then drop valid
    // unless the caller has another item ready in the same burst.
    task automatic send_vertex(input t_in_item it, input bit keep_valid);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (!keep_valid) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Wait until every expected result has arrived, then let the pipeline drain.
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // Mostly vertices near the pick point so that the brush is hit often.
    function automatic t_in_item rand_vertex();
        t_in_item it;
        logic [31:0] span;
        it.pick_x = rand_coord();
        it.pick_y = rand_coord();
        it.pick_z = rand_coord();
        span = 32'd1 << $urandom_range(4, 24);
        if ($urandom_range(0, 9) < 8) begin
            it.vertex_x = it.pick_x + $signed($urandom_range(0, span)) - $signed(span >> 1);
            it.vertex_z = it.pick_z + $signed($urandom_range(0, span)) - $signed(span >> 1);
        end else begin
            it.vertex_x = rand_coord();
            it.vertex_z = rand_coord();
        end
        case ($urandom_range(0, 3))
            0: it.vertex_y = it.pick_y + $signed($urandom_range(0, 13108)) - 6554;
            1: it.vertex_y = rand_coord();
            default: it.vertex_y = $urandom;
        endcase
        it.frame_time = 16'($urandom);
        it.opcode = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it.boost = 1'($urandom);
        it.apply = ($urandom_range(0, 4) != 0);
        return it;
    endfunction

    task automatic random_phase(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++) send_vertex(rand_vertex(), i < burst - 1);
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    function automatic t_in_item at_pick(input logic signed [31:0] off_x,
                                         input logic signed [31:0] vy,
                                         input logic [1:0] op);
        t_in_item it;
        it.pick_x = 32'sd1000;
        it.pick_y = 32'sd65536;
        it.pick_z = -32'sd2000;
        it.vertex_x = it.pick_x + off_x;
        it.vertex_y = vy;
        it.vertex_z = it.pick_z;
        it.frame_time = 16'hFFFF;
        it.opcode = op;
        it.boost = 1'b0;
        it.apply = 1'b1;
        return it;
    endfunction

    initial begin
        t_in_item it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: raise and lower at the center, flatten below, above and inside
        // the snap band, the rim, outside, far vertex, height saturation,
        // the unused mode and apply off.
        send_vertex(at_pick(0, 32'sd0, OP_RAISE), 0);
        send_vertex(at_pick(0, 32'sd0, OP_LOWER), 0);
        send_vertex(at_pick(100, 32'sd0, OP_FLATTEN), 0);
        send_vertex(at_pick(100, 32'sd200000, OP_FLATTEN), 0);
        send_vertex(at_pick(100, 32'sd65536 + 32'sd6554, OP_FLATTEN), 0);
        send_vertex(at_pick(100, 32'sd65536 - 32'sd6554, OP_FLATTEN), 0);
        send_vertex(at_pick(100, 32'sd65536 + 32'sd6555, OP_FLATTEN), 0);
        send_vertex(at_pick(327679, 32'sd5, OP_RAISE), 0);
        send_vertex(at_pick(327680, 32'sd5, OP_RAISE), 0);
        send_vertex(at_pick(0, 32'sh7FFF_FFF0, OP_RAISE), 0);
        send_vertex(at_pick(0, 32'sh8000_0010, OP_LOWER), 0);
        send_vertex(at_pick(0, 32'sd77, 2'd3), 0);
        it = at_pick(10, 32'sd77, OP_RAISE);
        it.apply = 1'b0;
        send_vertex(it, 0);
        it = at_pick(0, 32'sd0, OP_RAISE);
        it.boost = 1'b1;
        send_vertex(it, 0);
        it.pick_x = 32'sh7FFF_FFFF;
        it.vertex_x = 32'sh8000_0000;
        send_vertex(it, 0);
        it = at_pick(0, 32'sd0, OP_LOWER);
        it.pick_x = 32'sh8000_0000;
        it.vertex_x = 32'sh8000_0000;
        it.pick_z = 32'sh8000_0000;
        it.vertex_z = 32'sh7FFF_FFFF;
        send_vertex(it, 0);
        it = '1;
        it.opcode = OP_FLATTEN;
        send_vertex(it, 0);
        send_vertex('0, 0);
        random_phase(60);
        drain();

        // Extreme registers: maximum radius and speed, zero boost.
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_SPEED, 32'h7FFF_FFFF);
        write_reg(REG_BOOST, 32'h0000_0000);
        random_phase(120);
        drain();

        // Smallest nonzero radius, zero speed, maximum boost.
        write_reg(REG_RADIUS, 32'h0000_0001);
        write_reg(REG_SPEED, 32'h0000_0000);
        write_reg(REG_BOOST, 32'h0000_FFFF);
        send_vertex(at_pick(0, 32'sd3, OP_RAISE), 0);
        random_phase(60);
        drain();

        // Random settings over the rest of the run.
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_RADIUS, $urandom_range(1, 32'h0100_0000));
            write_reg(REG_SPEED, $urandom);
            write_reg(REG_BOOST, $urandom_range(0, 16'hFFFF));
            random_phase(100);
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
